// ===== hw/rtl/dte_pkg.sv =====
// Shared types and constants for the difference table extrapolator.
`timescale 1ns / 1ps
`default_nettype none

package dte_pkg;

  localparam int MaxSamples = 32;
  localparam int DataW      = 32;
  localparam int CountW     = $clog2(MaxSamples + 1);

  // Token that walks down the chain while a sample extends the table.
  typedef struct packed {
    logic             valid;
    logic [DataW-1:0] diff;
    logic             ovf;
  } fwd_tok_t;

  // Token that walks back up the chain while the final sums build.
  typedef struct packed {
    logic             valid;
    logic [DataW-1:0] nxt;
    logic [DataW-1:0] prv;
    logic             ovf;
  } back_tok_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FWD,
    S_SEED,
    S_BACK,
    S_HOLD
  } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dte_cell.sv =====
// One row cell: holds the first and last entry of one difference row.
`timescale 1ns / 1ps
`default_nettype none

module dte_cell (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    clear,
  input  dte_pkg::fwd_tok_t      fwd_in,
  output dte_pkg::fwd_tok_t      fwd_out,
  input  dte_pkg::back_tok_t     seed,
  input  dte_pkg::back_tok_t     back_in,
  output dte_pkg::back_tok_t     back_out,
  input  wire                    next_occ,
  output logic                   occ,
  output logic                   done,
  output logic                   done_ovf
);

  logic [dte_pkg::DataW-1:0] row_last;
  logic [dte_pkg::DataW-1:0] row_first;

  logic [dte_pkg::DataW-1:0] diff_next;
  logic                      diff_ovf;
  logic                      back_go;
  dte_pkg::back_tok_t        back_src;
  logic [dte_pkg::DataW-1:0] nxt_next;
  logic [dte_pkg::DataW-1:0] prv_next;
  logic                      nxt_ovf;
  logic                      prv_ovf;

  always_comb begin
    diff_next = fwd_in.diff - row_last;
    diff_ovf  = (fwd_in.diff[dte_pkg::DataW-1] ^ row_last[dte_pkg::DataW-1]) &
                (fwd_in.diff[dte_pkg::DataW-1] ^ diff_next[dte_pkg::DataW-1]);
  end

  // Start the backward walk at the deepest occupied row.
  always_comb begin
    back_go  = 1'b0;
    back_src = back_in;
    if (back_in.valid) begin
      back_go = 1'b1;
    end else if (seed.valid && occ && !next_occ) begin
      back_go  = 1'b1;
      back_src = seed;
    end
    nxt_next = back_src.nxt + row_last;
    nxt_ovf  = ~(back_src.nxt[dte_pkg::DataW-1] ^ row_last[dte_pkg::DataW-1]) &
               (back_src.nxt[dte_pkg::DataW-1] ^ nxt_next[dte_pkg::DataW-1]);
    prv_next = row_first - back_src.prv;
    prv_ovf  = (row_first[dte_pkg::DataW-1] ^ back_src.prv[dte_pkg::DataW-1]) &
               (row_first[dte_pkg::DataW-1] ^ prv_next[dte_pkg::DataW-1]);
  end

  always_ff @(posedge clk) begin
    fwd_out.diff <= diff_next;
    fwd_out.ovf  <= fwd_in.ovf | diff_ovf;
    done_ovf     <= fwd_in.ovf;
    back_out.nxt <= nxt_next;
    back_out.prv <= prv_next;
    back_out.ovf <= back_src.ovf | nxt_ovf | prv_ovf;
    if (rst || clear) begin
      occ            <= 1'b0;
      done           <= 1'b0;
      fwd_out.valid  <= 1'b0;
      back_out.valid <= 1'b0;
    end else begin
      done           <= 1'b0;
      fwd_out.valid  <= 1'b0;
      back_out.valid <= back_go;
      if (fwd_in.valid) begin
        if (occ) begin
          fwd_out.valid <= 1'b1;
        end else begin
          occ  <= 1'b1;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fwd_in.valid) begin
      row_last <= fwd_in.diff;
      if (!occ) begin
        row_first <= fwd_in.diff;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/difference_table_extrapolator_top.sv =====
// Top level: sample stream in, chain of row cells, extrapolated pair out.
`timescale 1ns / 1ps
`default_nettype none

// Takes one signed sample per item and, on the item flagged tlast, returns the
// next and previous terms of the sequence from its finite-difference table.
// Each row of the table lives in one cell of a chain; a sample walks down the
// chain one cell per cycle, and a sample that finds n samples already held
// must reach the first empty cell before the next item is taken. The final
// sample then walks back up the deepest n + 1 rows, one per cycle, and the
// result waits in a holding register for any previous result to leave the
// output register. Up to MaxSamples samples are held; later ones are dropped
// and raise the overflow flag, which also reports any wrap in a difference or
// in the final sums. After a result the chain is empty for the next sequence.
module difference_table_extrapolator_top (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [31:0] s_tdata,   // [31:0] sample_value
  input  wire         s_tlast,   // last_sample
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [63:0] m_tdata,   // [31:0] next_value, [63:32] prev_value
  output logic        m_tuser    // overflow
);

  localparam int N = dte_pkg::MaxSamples;

  dte_pkg::state_t           state;
  dte_pkg::state_t           state_next;
  logic [dte_pkg::CountW-1:0] count;
  logic                      ovf_seen;
  logic                      last_pend;
  logic [dte_pkg::DataW-1:0] res_nxt;
  logic [dte_pkg::DataW-1:0] res_prv;
  logic                      res_ovf;

  dte_pkg::fwd_tok_t  inject;
  dte_pkg::back_tok_t seed;
  dte_pkg::back_tok_t back_idle;
  dte_pkg::fwd_tok_t  fwd_link  [N];
  dte_pkg::back_tok_t back_link [N];
  logic [N-1:0]       occ_vec;
  logic [N-1:0]       done_vec;
  logic [N-1:0]       done_ovf_vec;

  logic in_acc;
  logic room;
  logic fwd_done;
  logic fwd_ovf;
  logic clear;
  logic out_free;

  assign in_acc   = s_tvalid && s_tready;
  assign room     = (count < dte_pkg::CountW'(N));
  assign fwd_done = |done_vec;
  assign fwd_ovf  = |(done_vec & done_ovf_vec);
  assign out_free = !m_tvalid || m_tready;
  assign clear    = (state == dte_pkg::S_BACK) && back_link[0].valid;

  always_comb begin
    state_next = state;
    unique case (state)
      dte_pkg::S_IDLE: begin
        if (in_acc) begin
          if (room) begin
            state_next = dte_pkg::S_FWD;
          end else if (s_tlast) begin
            state_next = dte_pkg::S_SEED;
          end
        end
      end
      dte_pkg::S_FWD: begin
        if (fwd_done) begin
          state_next = last_pend ? dte_pkg::S_SEED : dte_pkg::S_IDLE;
        end
      end
      dte_pkg::S_SEED: state_next = dte_pkg::S_BACK;
      dte_pkg::S_BACK: begin
        if (back_link[0].valid) begin
          state_next = dte_pkg::S_HOLD;
        end
      end
      dte_pkg::S_HOLD: begin
        if (out_free) begin
          state_next = dte_pkg::S_IDLE;
        end
      end
      default: state_next = dte_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    s_tready     = (state == dte_pkg::S_IDLE);
    inject.valid = in_acc && room;
    inject.diff  = s_tdata;
    inject.ovf   = 1'b0;
    seed.valid   = (state == dte_pkg::S_SEED);
    seed.nxt     = '0;
    seed.prv     = '0;
    seed.ovf     = ovf_seen;
    back_idle    = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dte_pkg::S_IDLE;
      count     <= '0;
      ovf_seen  <= 1'b0;
      last_pend <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      state <= state_next;
      if (in_acc) begin
        last_pend <= s_tlast;
        if (room) begin
          count <= count + 1'b1;
        end else begin
          ovf_seen <= 1'b1;
        end
      end
      if ((state == dte_pkg::S_FWD) && fwd_done && fwd_ovf) begin
        ovf_seen <= 1'b1;
      end
      // Empty the table once the sums are captured.
      if (clear) begin
        count    <= '0;
        ovf_seen <= 1'b0;
      end
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if ((state == dte_pkg::S_HOLD) && out_free) begin
        m_tvalid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      res_nxt <= back_link[0].nxt;
      res_prv <= back_link[0].prv;
      res_ovf <= back_link[0].ovf;
    end
    if ((state == dte_pkg::S_HOLD) && out_free) begin
      m_tdata <= {res_prv, res_nxt};
      m_tuser <= res_ovf;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_cell
    dte_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .clear    (clear),
      .fwd_in   ((k == 0) ? inject : fwd_link[(k == 0) ? 0 : k - 1]),
      .fwd_out  (fwd_link[k]),
      .seed     (seed),
      .back_in  ((k == N - 1) ? back_idle : back_link[(k == N - 1) ? k : k + 1]),
      .back_out (back_link[k]),
      .next_occ ((k == N - 1) ? 1'b0 : occ_vec[(k == N - 1) ? k : k + 1]),
      .occ      (occ_vec[k]),
      .done     (done_vec[k]),
      .done_ovf (done_ovf_vec[k])
    );
  end

endmodule

`default_nettype wire
